>>> rtl/lspe_pkg.sv
package lspe_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned THRESH_W   = 10;
  localparam int unsigned FILL_W     = 12;
  localparam int unsigned HOME_W     = 12;
  localparam int unsigned COLOUR_W   = 8;
  localparam int unsigned DIV_CNT_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_DISTANCE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_ENABLE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_X          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_Y          = 3'd4;

  localparam logic [THRESH_W-1:0] LIGHT_THRESHOLD_RST = 10'd50;
  localparam logic [FILL_W-1:0]   FILL_DISTANCE_RST   = 12'd10;
  localparam logic                BOOST_ENABLE_RST    = 1'b1;
  localparam logic [HOME_W-1:0]   HOME_X_RST          = 12'd450;
  localparam logic [HOME_W-1:0]   HOME_Y_RST          = 12'd300;

  localparam logic [COLOUR_W-1:0] COLOUR_FULL = 8'd255;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 3'd7;

  typedef struct packed {
    logic [THRESH_W-1:0] light_threshold;
    logic [FILL_W-1:0]   fill_distance;
    logic                boost_enable;
    logic [HOME_W-1:0]   home_x;
    logic [HOME_W-1:0]   home_y;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CHECK,
    ST_DIV,
    ST_SCALE,
    ST_GAP,
    ST_BLANK_LAST,
    ST_BLANK_START,
    ST_LIT_START,
    ST_LIT_END
  } state_e;

  typedef enum logic [1:0] {
    SEL_LAST,
    SEL_START_DARK,
    SEL_START_LIT,
    SEL_END_LIT
  } point_sel_e;

  typedef struct packed {
    logic       capture;
    logic       eval;
    logic       div_start;
    logic       scale;
    logic       load_out;
    point_sel_e sel;
    logic       upd_last;
  } cmd_t;

  typedef struct packed {
    logic lit;
    logic div_done;
    logic gap;
    logic out_free;
  } status_t;

endpackage

>>> rtl/lspe_div.sv
module lspe_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lspe_pkg::COLOUR_W-1:0] divisor_i,
  output logic                          done_o,
  output logic [lspe_pkg::COLOUR_W-1:0] quot_o
);
  import lspe_pkg::*;

  logic                  busy_q, busy_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [COLOUR_W-1:0]   rem_q, rem_d;
  logic [COLOUR_W-1:0]   quo_q, quo_d;
  logic [COLOUR_W-1:0]   div_q, div_d;
  logic [COLOUR_W:0]     rem_shift;
  logic                  ge;

  assign rem_shift = {rem_q, quo_q[COLOUR_W-1]};
  assign ge        = rem_shift >= {1'b0, div_q};
  assign done_o    = busy_q && (cnt_q == DIV_LAST_STEP);
  assign quot_o    = quo_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = COLOUR_FULL;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? COLOUR_W'(rem_shift - {1'b0, div_q}) : rem_shift[COLOUR_W-1:0];
      quo_d = {quo_q[COLOUR_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_LAST_STEP) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

endmodule

>>> rtl/lspe_cfg.sv
module lspe_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lspe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lspe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output lspe_pkg::cfg_t                  cfg_o
);
  import lspe_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LIGHT_THRESHOLD: cfg_d.light_threshold = cfg_data_i[THRESH_W-1:0];
        CFG_FILL_DISTANCE:   cfg_d.fill_distance   = cfg_data_i[FILL_W-1:0];
        CFG_BOOST_ENABLE:    cfg_d.boost_enable    = cfg_data_i[0];
        CFG_HOME_X:          cfg_d.home_x          = cfg_data_i[HOME_W-1:0];
        CFG_HOME_Y:          cfg_d.home_y          = cfg_data_i[HOME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.light_threshold <= LIGHT_THRESHOLD_RST;
      cfg_q.fill_distance   <= FILL_DISTANCE_RST;
      cfg_q.boost_enable    <= BOOST_ENABLE_RST;
      cfg_q.home_x          <= HOME_X_RST;
      cfg_q.home_y          <= HOME_Y_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> rtl/lspe_ctrl.sv
module lspe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lspe_pkg::status_t status_i,
  output lspe_pkg::cmd_t    cmd_o
);
  import lspe_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_EVAL;
      ST_EVAL:  state_d = ST_CHECK;
      ST_CHECK: state_d = status_i.lit ? ST_DIV : ST_IDLE;
      ST_DIV:   if (status_i.div_done) state_d = ST_SCALE;
      ST_SCALE: state_d = ST_GAP;
      ST_GAP:   state_d = status_i.gap ? ST_BLANK_LAST : ST_LIT_START;
      ST_BLANK_LAST:  if (status_i.out_free) state_d = ST_BLANK_START;
      ST_BLANK_START: if (status_i.out_free) state_d = ST_LIT_START;
      ST_LIT_START:   if (status_i.out_free) state_d = ST_LIT_END;
      ST_LIT_END:     if (status_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o.capture     = 1'b0;
    cmd_o.eval        = 1'b0;
    cmd_o.div_start   = 1'b0;
    cmd_o.scale       = 1'b0;
    cmd_o.load_out    = 1'b0;
    cmd_o.sel         = SEL_LAST;
    cmd_o.upd_last    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EVAL:  cmd_o.eval = 1'b1;
      ST_CHECK: cmd_o.div_start = status_i.lit;
      ST_SCALE: cmd_o.scale = 1'b1;
      ST_BLANK_LAST: begin
        cmd_o.load_out = status_i.out_free;
        cmd_o.sel      = SEL_LAST;
      end
      ST_BLANK_START: begin
        cmd_o.load_out = status_i.out_free;
        cmd_o.sel      = SEL_START_DARK;
      end
      ST_LIT_START: begin
        cmd_o.load_out = status_i.out_free;
        cmd_o.sel      = SEL_START_LIT;
      end
      ST_LIT_END: begin
        cmd_o.load_out = status_i.out_free;
        cmd_o.sel      = SEL_END_LIT;
        cmd_o.upd_last = status_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/lspe_datapath.sv
module lspe_datapath #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned IN_W       = 96,
  parameter int unsigned OUT_W      = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lspe_pkg::cfg_t    cfg_i,
  input  lspe_pkg::cmd_t    cmd_i,
  output lspe_pkg::status_t status_o,
  input  logic [IN_W-1:0]   in_data_i,
  input  logic              in_frame_start_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OUT_W-1:0]  out_data_o,
  output logic              out_last_o
);
  import lspe_pkg::*;

  localparam int unsigned CB     = COORD_BITS;
  localparam int unsigned SQ_W   = 2 * CB;
  localparam int unsigned D2_W   = SQ_W + 1;
  localparam int unsigned F2_W   = 2 * FILL_W;
  localparam int unsigned CMP_W  = (D2_W > F2_W) ? D2_W : F2_W;
  localparam int unsigned COL0   = 4 * CB;
  localparam logic [CB-1:0] LAST_X_RST = CB'(HOME_X_RST);
  localparam logic [CB-1:0] LAST_Y_RST = CB'(HOME_Y_RST);

  logic [CB-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [COLOUR_W-1:0] sb_q, sg_q, sr_q, eb_q, eg_q, er_q;
  logic [CB-1:0] last_x_q, last_x_d, last_y_q, last_y_d;

  logic [COLOUR_W-1:0] avg_b, avg_g, avg_r;
  logic [THRESH_W-1:0] chan_sum;
  logic [COLOUR_W-1:0] max_bg, max_all;
  logic [CB-1:0]       dx, dy;

  logic [COLOUR_W-1:0] avg_b_q, avg_g_q, avg_r_q, max_q;
  logic                lit_q;
  logic [CB-1:0]       dx_q, dy_q;
  logic [SQ_W-1:0]     dx2_q, dy2_q;
  logic [F2_W-1:0]     f2_q;
  logic [CMP_W-1:0]    d2_ext, f2_ext;

  logic                div_done;
  logic [COLOUR_W-1:0] quot;
  logic                boost;
  logic [COLOUR_W-1:0] col_b_q, col_g_q, col_r_q;

  logic                out_valid_q, out_valid_d;
  logic [OUT_W-1:0]    out_data_q;
  logic                out_last_q;
  logic                out_free;
  logic [CB-1:0]       pt_x, pt_y;
  logic [COLOUR_W-1:0] pt_b, pt_g, pt_r;
  logic                pt_last;

  lspe_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .divisor_i (max_q),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign avg_b = COLOUR_W'(({1'b0, sb_q} + {1'b0, eb_q}) >> 1);
  assign avg_g = COLOUR_W'(({1'b0, sg_q} + {1'b0, eg_q}) >> 1);
  assign avg_r = COLOUR_W'(({1'b0, sr_q} + {1'b0, er_q}) >> 1);
  assign chan_sum = THRESH_W'(avg_b) + THRESH_W'(avg_g) + THRESH_W'(avg_r);
  assign max_bg   = (avg_g > avg_b) ? avg_g : avg_b;
  assign max_all  = (avg_r > max_bg) ? avg_r : max_bg;
  assign dx = (sx_q >= last_x_q) ? (sx_q - last_x_q) : (last_x_q - sx_q);
  assign dy = (sy_q >= last_y_q) ? (sy_q - last_y_q) : (last_y_q - sy_q);

  assign d2_ext = CMP_W'(D2_W'(dx2_q) + D2_W'(dy2_q));
  assign f2_ext = CMP_W'(f2_q);
  assign boost  = cfg_i.boost_enable && (max_q != '0);

  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.lit      = lit_q;
  assign status_o.div_done = div_done;
  assign status_o.gap      = d2_ext > f2_ext;
  assign status_o.out_free = out_free;

  always_comb begin
    last_x_d = last_x_q;
    last_y_d = last_y_q;
    if (cmd_i.capture && in_frame_start_i) begin
      last_x_d = CB'(cfg_i.home_x);
      last_y_d = CB'(cfg_i.home_y);
    end else if (cmd_i.upd_last) begin
      last_x_d = ex_q;
      last_y_d = ey_q;
    end
  end

  always_comb begin
    pt_x    = sx_q;
    pt_y    = sy_q;
    pt_b    = '0;
    pt_g    = '0;
    pt_r    = '0;
    pt_last = 1'b0;
    unique case (cmd_i.sel)
      SEL_LAST: begin
        pt_x = last_x_q;
        pt_y = last_y_q;
      end
      SEL_START_DARK: ;
      SEL_START_LIT: begin
        pt_b = col_b_q;
        pt_g = col_g_q;
        pt_r = col_r_q;
      end
      SEL_END_LIT: begin
        pt_x    = ex_q;
        pt_y    = ey_q;
        pt_b    = col_b_q;
        pt_g    = col_g_q;
        pt_r    = col_r_q;
        pt_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q    <= LAST_X_RST;
      last_y_q    <= LAST_Y_RST;
      out_valid_q <= 1'b0;
    end else begin
      last_x_q    <= last_x_d;
      last_y_q    <= last_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sx_q <= in_data_i[0*CB +: CB];
      sy_q <= in_data_i[1*CB +: CB];
      ex_q <= in_data_i[2*CB +: CB];
      ey_q <= in_data_i[3*CB +: CB];
      sb_q <= in_data_i[COL0 + 0*COLOUR_W +: COLOUR_W];
      sg_q <= in_data_i[COL0 + 1*COLOUR_W +: COLOUR_W];
      sr_q <= in_data_i[COL0 + 2*COLOUR_W +: COLOUR_W];
      eb_q <= in_data_i[COL0 + 3*COLOUR_W +: COLOUR_W];
      eg_q <= in_data_i[COL0 + 4*COLOUR_W +: COLOUR_W];
      er_q <= in_data_i[COL0 + 5*COLOUR_W +: COLOUR_W];
    end
    if (cmd_i.eval) begin
      avg_b_q <= avg_b;
      avg_g_q <= avg_g;
      avg_r_q <= avg_r;
      max_q   <= max_all;
      lit_q   <= chan_sum >= cfg_i.light_threshold;
      dx_q    <= dx;
      dy_q    <= dy;
    end
    dx2_q <= SQ_W'(dx_q) * SQ_W'(dx_q);
    dy2_q <= SQ_W'(dy_q) * SQ_W'(dy_q);
    f2_q  <= F2_W'(cfg_i.fill_distance) * F2_W'(cfg_i.fill_distance);
    if (cmd_i.scale) begin
      if (boost) begin
        col_b_q <= COLOUR_W'(avg_b_q * quot);
        col_g_q <= COLOUR_W'(avg_g_q * quot);
        col_r_q <= COLOUR_W'(avg_r_q * quot);
      end else begin
        col_b_q <= avg_b_q;
        col_g_q <= avg_g_q;
        col_r_q <= avg_r_q;
      end
    end
    if (cmd_i.load_out) begin
      out_data_q <= OUT_W'({pt_r, pt_g, pt_b, pt_y, pt_x});
      out_last_q <= pt_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

>>> rtl/laser_segment_point_emitter.sv
// Turns one line segment per request into beam points for a laser scanner. A segment is taken
// only while the block is idle; it is then evaluated for brightness, its colour is boosted
// (when boost is enabled) through an eight-step shift-subtract divider, and the gap from the
// last beam position is compared against the fill distance. A dark segment returns the block
// to idle right after the brightness check. A lit segment emits 2 or 4 points and holds the
// block until its final point is loaded, waiting while the output register holds a point.
// Points leave through a single output register, and the next segment is accepted
// while the final point of the previous one still waits there.
module laser_segment_point_emitter #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lspe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lspe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // start_x, start_y, end_x, end_y, start_blue, start_green, start_red,
  // end_blue, end_green, end_red, zero padding
  input  logic [((4*COORD_BITS+48+7)/8)*8-1:0] s_axis_tdata,
  // frame_start
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // point_x, point_y, beam_blue, beam_green, beam_red, zero padding
  output logic [((2*COORD_BITS+24+7)/8)*8-1:0] m_axis_tdata,
  output logic                            m_axis_tlast
);
  import lspe_pkg::*;

  localparam int unsigned IN_W  = ((4*COORD_BITS+48+7)/8)*8;
  localparam int unsigned OUT_W = ((2*COORD_BITS+24+7)/8)*8;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  lspe_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lspe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lspe_datapath #(
    .COORD_BITS (COORD_BITS),
    .IN_W       (IN_W),
    .OUT_W      (OUT_W)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .status_o         (status),
    .in_data_i        (s_axis_tdata),
    .in_frame_start_i (s_axis_tuser),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_o       (m_axis_tdata),
    .out_last_o       (m_axis_tlast)
  );

  // A new segment is never taken on the next cycle after one was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("segment accepted twice in consecutive cycles");

  // Only the final point of a run may still be pending when a new segment is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && m_axis_tvalid) |-> m_axis_tlast)
    else $error("segment accepted while its predecessor is still emitting");

  // The divider only finishes while a boost factor is awaited.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_done |-> !s_axis_tready && !cmd.load_out)
    else $error("divider finished outside the scaling phase");

endmodule

>>> test/laser_segment_point_emitter_test.sv
`timescale 1ns / 1ps

module laser_segment_point_emitter_test;
  import lspe_pkg::*;

  localparam int unsigned COORD_BITS   = 12;
  localparam int unsigned IN_W         = ((4*COORD_BITS+48+7)/8)*8;
  localparam int unsigned OUT_W        = ((2*COORD_BITS+24+7)/8)*8;
  localparam int unsigned COORD_MAX    = (1 << COORD_BITS) - 1;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned IDLE_PCT     = 30;
  localparam int unsigned RAND_PHASES  = 6;
  localparam int unsigned RAND_ITEMS   = 70;
  localparam int unsigned MAX_PRINTED  = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic                  frame_start;
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
    logic [COLOUR_W-1:0]   sb;
    logic [COLOUR_W-1:0]   sg;
    logic [COLOUR_W-1:0]   sr;
    logic [COLOUR_W-1:0]   eb;
    logic [COLOUR_W-1:0]   eg;
    logic [COLOUR_W-1:0]   er;
  } segment_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOUR_W-1:0]   b;
    logic [COLOUR_W-1:0]   g;
    logic [COLOUR_W-1:0]   r;
    logic                  last;
  } point_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  m_axis_tlast;

  segment_t pending_segments[$];
  point_t   expected_points[$];

  logic [THRESH_W-1:0]   thr_now;
  logic [FILL_W-1:0]     fill_now;
  logic                  boost_now;
  logic [HOME_W-1:0]     home_x_now;
  logic [HOME_W-1:0]     home_y_now;
  logic [COORD_BITS-1:0] beam_x;
  logic [COORD_BITS-1:0] beam_y;

  int unsigned idle_pct = IDLE_PCT;
  bit          in_flight = 1'b0;
  int unsigned mismatches = 0;
  int unsigned segments_taken = 0;
  int unsigned segments_dropped = 0;
  int unsigned blank_moves = 0;
  int unsigned points_checked = 0;
  point_t      got_point;
  point_t      want_point;

  laser_segment_point_emitter #(
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    begin
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, what);
    end
  endtask

  task automatic append_expected(input point_t p);
    begin
      expected_points.insert(expected_points.size(), p);
    end
  endtask

  task automatic append_segment(input segment_t s);
    begin
      pending_segments.insert(pending_segments.size(), s);
    end
  endtask

  function automatic point_t make_point(input logic [COORD_BITS-1:0] x, y,
                                        input logic [COLOUR_W-1:0] b, g, r,
                                        input logic last);
    point_t p;
    begin
      p.x = x;
      p.y = y;
      p.b = b;
      p.g = g;
      p.r = r;
      p.last = last;
      return p;
    end
  endfunction

  task automatic plan_points(input segment_t s);
    logic [COLOUR_W-1:0] b, g, r, mx, f;
    int unsigned dx, dy, d2, f2;
    begin
      if (s.frame_start) begin
        beam_x = home_x_now;
        beam_y = home_y_now;
      end
      b = ({1'b0, s.sb} + {1'b0, s.eb}) >> 1;
      g = ({1'b0, s.sg} + {1'b0, s.eg}) >> 1;
      r = ({1'b0, s.sr} + {1'b0, s.er}) >> 1;
      if (int'(b) + int'(g) + int'(r) < int'(thr_now)) begin
        segments_dropped++;
      end else begin
        mx = b;
        if (g > mx) mx = g;
        if (r > mx) mx = r;
        if (boost_now && mx != 0) begin
          f = 8'(255 / int'(mx));
          b = 8'(int'(b) * int'(f));
          g = 8'(int'(g) * int'(f));
          r = 8'(int'(r) * int'(f));
        end
        dx = (s.sx >= beam_x) ? int'(s.sx) - int'(beam_x) : int'(beam_x) - int'(s.sx);
        dy = (s.sy >= beam_y) ? int'(s.sy) - int'(beam_y) : int'(beam_y) - int'(s.sy);
        d2 = dx * dx + dy * dy;
        f2 = int'(fill_now) * int'(fill_now);
        if (d2 > f2) begin
          append_expected(make_point(beam_x, beam_y, '0, '0, '0, 1'b0));
          append_expected(make_point(s.sx, s.sy, '0, '0, '0, 1'b0));
          blank_moves++;
        end
        append_expected(make_point(s.sx, s.sy, b, g, r, 1'b0));
        append_expected(make_point(s.ex, s.ey, b, g, r, 1'b1));
        beam_x = s.ex;
        beam_y = s.ey;
      end
    end
  endtask

  // Segment driver: a request is held until it is taken.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      plan_points(pending_segments[0]);
      void'(pending_segments.pop_front());
      segments_taken++;
      in_flight = 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (!in_flight) begin
      if (pending_segments.size() != 0 && $urandom_range(99) >= idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({pending_segments[0].er, pending_segments[0].eg,
                                pending_segments[0].eb, pending_segments[0].sr,
                                pending_segments[0].sg, pending_segments[0].sb,
                                pending_segments[0].ey, pending_segments[0].ex,
                                pending_segments[0].sy, pending_segments[0].sx});
        s_axis_tuser  <= pending_segments[0].frame_start;
        in_flight = 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  // Point monitor.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_point.x    = m_axis_tdata[COORD_BITS-1:0];
      got_point.y    = m_axis_tdata[2*COORD_BITS-1:COORD_BITS];
      got_point.b    = m_axis_tdata[2*COORD_BITS+7:2*COORD_BITS];
      got_point.g    = m_axis_tdata[2*COORD_BITS+15:2*COORD_BITS+8];
      got_point.r    = m_axis_tdata[2*COORD_BITS+23:2*COORD_BITS+16];
      got_point.last = m_axis_tlast;
      if (expected_points.size() == 0) begin
        report_mismatch($sformatf("point (%0d,%0d) with nothing expected",
                                  got_point.x, got_point.y));
      end else begin
        want_point = expected_points.pop_front();
        points_checked++;
        if (got_point.x !== want_point.x)
          report_mismatch($sformatf("point_x %0d, expected %0d", got_point.x, want_point.x));
        if (got_point.y !== want_point.y)
          report_mismatch($sformatf("point_y %0d, expected %0d", got_point.y, want_point.y));
        if (got_point.b !== want_point.b)
          report_mismatch($sformatf("beam_blue %0d, expected %0d", got_point.b, want_point.b));
        if (got_point.g !== want_point.g)
          report_mismatch($sformatf("beam_green %0d, expected %0d", got_point.g, want_point.g));
        if (got_point.r !== want_point.r)
          report_mismatch($sformatf("beam_red %0d, expected %0d", got_point.r, want_point.r));
        if (got_point.last !== want_point.last)
          report_mismatch($sformatf("run_last %0d, expected %0d", got_point.last,
                                    want_point.last));
      end
    end
  end

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= CFG_DATA_W'(value);
      @(negedge clk_i);
      cfg_we_i   <= 1'b0;
      case (idx)
        CFG_LIGHT_THRESHOLD: thr_now    = THRESH_W'(value);
        CFG_FILL_DISTANCE:   fill_now   = FILL_W'(value);
        CFG_BOOST_ENABLE:    boost_now  = value[0];
        CFG_HOME_X:          home_x_now = HOME_W'(value);
        CFG_HOME_Y:          home_y_now = HOME_W'(value);
        default: ;
      endcase
    end
  endtask

  task automatic configure(input int unsigned thr, fill, boost, hx, hy);
    begin
      set_register(CFG_LIGHT_THRESHOLD, thr);
      set_register(CFG_FILL_DISTANCE, fill);
      set_register(CFG_BOOST_ENABLE, boost);
      set_register(CFG_HOME_X, hx);
      set_register(CFG_HOME_Y, hy);
    end
  endtask

  // Waits until every point is out, then long enough for a dropped segment to clear.
  task automatic drain();
    begin
      while (pending_segments.size() != 0 || expected_points.size() != 0) @(negedge clk_i);
      repeat (DRAIN_CYCLES) @(negedge clk_i);
    end
  endtask

  task automatic queue_segment(input logic fs, input int unsigned sx, sy, ex, ey,
                               input int unsigned sb, sg, sr, eb, eg, er);
    segment_t s;
    begin
      s.frame_start = fs;
      s.sx = COORD_BITS'(sx);
      s.sy = COORD_BITS'(sy);
      s.ex = COORD_BITS'(ex);
      s.ey = COORD_BITS'(ey);
      s.sb = COLOUR_W'(sb);
      s.sg = COLOUR_W'(sg);
      s.sr = COLOUR_W'(sr);
      s.eb = COLOUR_W'(eb);
      s.eg = COLOUR_W'(eg);
      s.er = COLOUR_W'(er);
      append_segment(s);
    end
  endtask

  function automatic logic [COLOUR_W-1:0] random_colour(input int unsigned mode);
    begin
      case (mode)
        0:       return COLOUR_W'($urandom_range(40));
        1:       return $urandom_range(1) ? COLOUR_FULL : '0;
        default: return COLOUR_W'($urandom_range(255));
      endcase
    end
  endfunction

  function automatic int unsigned clamp_coord(input int v);
    begin
      if (v < 0) return 0;
      if (v > int'(COORD_MAX)) return COORD_MAX;
      return v;
    end
  endfunction

  // Mostly chained segments whose start sits near the previous end, so that gaps land
  // around the fill distance; the rest jump anywhere.
  function automatic segment_t random_segment(input logic fs, input int from_x, from_y,
                                              input int fill);
    segment_t s;
    int kind, ox, oy, span, mode;
    begin
      s.frame_start = fs;
      kind = $urandom_range(9);
      if (kind < 3) begin
        ox = fill + int'($urandom_range(2)) - 1;
        if ($urandom_range(1)) ox = -ox;
        oy = 0;
        if ($urandom_range(1)) begin
          oy = ox;
          ox = 0;
        end
        s.sx = COORD_BITS'(clamp_coord(from_x + ox));
        s.sy = COORD_BITS'(clamp_coord(from_y + oy));
      end else if (kind < 6) begin
        span = (fill > 60) ? 64 : fill + 3;
        s.sx = COORD_BITS'(clamp_coord(from_x + int'($urandom_range(2*span)) - span));
        s.sy = COORD_BITS'(clamp_coord(from_y + int'($urandom_range(2*span)) - span));
      end else begin
        s.sx = COORD_BITS'($urandom_range(COORD_MAX));
        s.sy = COORD_BITS'($urandom_range(COORD_MAX));
      end
      if ($urandom_range(1)) begin
        s.ex = COORD_BITS'($urandom_range(COORD_MAX));
        s.ey = COORD_BITS'($urandom_range(COORD_MAX));
      end else begin
        s.ex = COORD_BITS'(clamp_coord(int'(s.sx) + int'($urandom_range(400)) - 200));
        s.ey = COORD_BITS'(clamp_coord(int'(s.sy) + int'($urandom_range(400)) - 200));
      end
      mode = ($urandom_range(9) < 7) ? 2 : $urandom_range(1);
      s.sb = random_colour(mode);
      s.sg = random_colour(mode);
      s.sr = random_colour(mode);
      s.eb = random_colour(mode);
      s.eg = random_colour(mode);
      s.er = random_colour(mode);
      return s;
    end
  endfunction

  initial begin : stimulus
    int unsigned phase, n, fill_pick;
    int          gen_x, gen_y;
    logic        fs;
    segment_t    s;
    thr_now    = LIGHT_THRESHOLD_RST;
    fill_now   = FILL_DISTANCE_RST;
    boost_now  = BOOST_ENABLE_RST;
    home_x_now = HOME_X_RST;
    home_y_now = HOME_Y_RST;
    beam_x     = HOME_X_RST;
    beam_y     = HOME_Y_RST;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: gap equal to and just over the fill distance, dropped segments
    // with and without a frame start, threshold met exactly, and boost factors.
    queue_segment(1'b1, 450, 300, 460, 300, 200, 100, 50, 200, 100, 50);
    queue_segment(1'b0, 470, 300, 0, 0, 127, 127, 0, 127, 127, 1);
    queue_segment(1'b0, 11, 0, 4095, 4095, 255, 255, 255, 254, 254, 254);
    queue_segment(1'b0, 4095, 4095, 0, 0, 32, 32, 34, 0, 0, 0);
    queue_segment(1'b1, 4095, 0, 0, 4095, 32, 32, 34, 0, 0, 0);
    queue_segment(1'b0, 450, 311, 0, 4095, 100, 0, 0, 0, 0, 0);
    queue_segment(1'b0, 0, 4095, 4095, 0, 255, 0, 255, 255, 0, 255);
    queue_segment(1'b0, 4095, 0, 4095, 4095, 0, 128, 0, 0, 128, 0);
    queue_segment(1'b0, 4095, 4095, 0, 0, 85, 0, 0, 85, 0, 0);
    queue_segment(1'b0, 0, 0, 4095, 4095, 0, 0, 255, 0, 0, 255);
    drain();

    // Zero threshold lets a black segment through; a largest channel of one boosts fully.
    configure(0, 4095, 1, 0, 0);
    queue_segment(1'b1, 4095, 4095, 4095, 0, 0, 0, 0, 0, 0, 0);
    queue_segment(1'b1, 4095, 0, 0, 0, 1, 0, 0, 2, 0, 0);
    queue_segment(1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_segment(1'b0, 1, 0, 2, 2, 0, 1, 0, 0, 1, 0);
    drain();

    configure(765, 1, 0, 4095, 4095);
    set_register(CFG_UNUSED, 'hABC);
    queue_segment(1'b1, 4095, 4094, 4094, 4094, 255, 255, 255, 255, 255, 255);
    queue_segment(1'b0, 4095, 4095, 4093, 4094, 255, 255, 255, 255, 255, 255);
    queue_segment(1'b0, 0, 0, 0, 0, 255, 255, 255, 255, 255, 254);
    queue_segment(1'b1, 0, 0, 0, 0, 255, 255, 255, 255, 255, 255);
    drain();

    for (phase = 0; phase < RAND_PHASES; phase++) begin
      fill_pick = $urandom_range(2);
      configure(($urandom_range(3) == 0) ? $urandom_range(1, 765) : $urandom_range(1, 200),
                (fill_pick == 0) ? $urandom_range(1, 32) :
                (fill_pick == 1) ? $urandom_range(1, 4095) : $urandom_range(200, 1000),
                phase % 2, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
      idle_pct = (phase == 3) ? 0 : IDLE_PCT;
      gen_x = int'(beam_x);
      gen_y = int'(beam_y);
      for (n = 0; n < RAND_ITEMS; n++) begin
        fs = ($urandom_range(9) == 0);
        if (fs) begin
          gen_x = int'(home_x_now);
          gen_y = int'(home_y_now);
        end
        s = random_segment(fs, gen_x, gen_y, int'(fill_now));
        append_segment(s);
        gen_x = int'(s.ex);
        gen_y = int'(s.ey);
      end
      drain();
    end

    $display("%0d segments taken (%0d dropped), %0d points checked, %0d blank moves",
             segments_taken, segments_dropped, points_checked, blank_moves);
    $display("covered %0d register settings, frame starts, stalls on both sides",
             RAND_PHASES + 3);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("timed out with %0d points still expected", expected_points.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
